// ----- design/rtp_header_payload_locator_macros.svh -----
// Assertion macros used by the RTP header payload locator parser.
`ifndef RTP_HEADER_PAYLOAD_LOCATOR_MACROS_SVH
`define RTP_HEADER_PAYLOAD_LOCATOR_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define RTPHPL_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside reset.
`define RTPHPL_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- design/rtphpl_pkg.sv -----
// Package: types, status codes and header constants of the RTP header payload locator.
package rtphpl_pkg;

  localparam int unsigned COUNT_W = 12;
  localparam int unsigned START_W = 19;
  localparam int unsigned PLEN_W  = 21;

  // Result status codes
  localparam logic [1:0] ST_NOT_RTP   = 2'd0;
  localparam logic [1:0] ST_RTP       = 2'd1;
  localparam logic [1:0] ST_MALFORMED = 2'd2;
  localparam logic [1:0] ST_TOO_LONG  = 2'd3;

  // First header byte fields
  localparam logic [7:0] VERSION_MASK = 8'hC0;
  localparam logic [7:0] VERSION_RTP  = 8'h80;
  localparam logic [7:0] CC_MASK      = 8'h0F;
  localparam logic [7:0] EXT_FLAG     = 8'h10;
  localparam logic [7:0] PAD_FLAG     = 8'h20;

  localparam logic [COUNT_W-1:0] FIXED_HDR_BYTES = 12'd12;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       last_byte;
  } item_t;

  typedef struct packed {
    logic       valid;
    item_t      item;
  } stage_t;

  typedef struct packed {
    logic [1:0]         status;
    logic [COUNT_W-1:0] payload_offset;
    logic [COUNT_W-1:0] payload_length;
    logic [15:0]        sequence_number;
  } result_t;

endpackage

// ----- design/rtphpl_if.sv -----
// Interfaces: byte input channel and result channel.
interface rtphpl_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       last_byte;

  modport source (output valid, output data_byte, output last_byte, input ready);
  modport sink (input valid, input data_byte, input last_byte, output ready);
endinterface

interface rtphpl_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  status;
  logic [11:0] payload_offset;
  logic [11:0] payload_length;
  logic [15:0] sequence_number;

  modport source (output valid, output status, output payload_offset,
                  output payload_length, output sequence_number, input ready);
  modport sink (input valid, input status, input payload_offset,
                input payload_length, input sequence_number, output ready);
endinterface

// ----- design/rtphpl_in_reg.sv -----
// Input register: holds one byte item until the parser takes it.
module rtphpl_in_reg (
  input  logic                  clk,
  input  logic                  rst_n,
  rtphpl_in_if.sink             in_ch,
  input  logic                  advance,
  output rtphpl_pkg::stage_t    stage
);

  logic                valid_r;
  logic                valid_nxt;
  rtphpl_pkg::item_t   item_r;
  logic                load;

  // Accept when empty or when the held item moves on
  assign in_ch.ready = !valid_r || advance;
  assign load        = in_ch.valid && in_ch.ready;

  always_comb begin
    valid_nxt = valid_r;
    if (load) begin
      valid_nxt = 1'b1;
    end else if (advance) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  // Payload needs no reset
  always_ff @(posedge clk) begin
    if (load) begin
      item_r.data_byte <= in_ch.data_byte;
      item_r.last_byte <= in_ch.last_byte;
    end
  end

  assign stage.valid = valid_r;
  assign stage.item  = item_r;

endmodule

// ----- design/rtphpl_parse.sv -----
// Parser: per-packet capture registers and result computation for the last byte.
`include "rtp_header_payload_locator_macros.svh"

module rtphpl_parse #(
  parameter int unsigned MAX_PACKET_BYTES = 2048
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  rtphpl_pkg::stage_t    stage,
  input  logic                  advance,
  output logic                  res_valid,
  output rtphpl_pkg::result_t   res
);

  localparam logic [rtphpl_pkg::COUNT_W-1:0] MAX_C =
    rtphpl_pkg::COUNT_W'(MAX_PACKET_BYTES);

  logic [rtphpl_pkg::COUNT_W-1:0] byte_count_r, count_nxt;
  logic [7:0]                     header_flags_r, flags_nxt;
  logic [15:0]                    sequence_capture_r, seq_nxt;
  logic [15:0]                    extension_words_r, ext_nxt;
  logic                           overlong_r, overlong_nxt;

  logic [7:0]                     b;
  logic                           below_max;
  logic [6:0]                     ext_pos;
  logic [rtphpl_pkg::COUNT_W-1:0] ext_pos_w;
  logic                           hit_hi, hit_lo;

  logic [6:0]                     start_base;
  logic                           ext_on, pad_on, short_pkt, bad_ver, trunc;
  logic [rtphpl_pkg::START_W-1:0] ext_add, start_full;
  logic [7:0]                     pad;
  logic signed [rtphpl_pkg::PLEN_W-1:0] plen;

  assign b         = stage.item.data_byte;
  assign below_max = byte_count_r < MAX_C;

  // Locate the extension length bytes after the CSRC list
  assign ext_pos   = 7'd12 + {1'b0, header_flags_r[3:0], 2'b00};
  assign ext_pos_w = {5'b0, ext_pos};
  assign hit_hi    = below_max && (byte_count_r >= rtphpl_pkg::FIXED_HDR_BYTES)
                     && (byte_count_r == ext_pos_w + 12'd2);
  assign hit_lo    = below_max && (byte_count_r >= rtphpl_pkg::FIXED_HDR_BYTES)
                     && (byte_count_r == ext_pos_w + 12'd3);

  // Capture state as seen after this byte
  always_comb begin
    count_nxt    = byte_count_r;
    flags_nxt    = header_flags_r;
    seq_nxt      = sequence_capture_r;
    ext_nxt      = extension_words_r;
    overlong_nxt = overlong_r;
    if (below_max) begin
      count_nxt = byte_count_r + 12'd1;
      if (byte_count_r == 12'd0) begin
        flags_nxt = b;
      end
      if (byte_count_r == 12'd2) begin
        seq_nxt = {b, sequence_capture_r[7:0]};
      end
      if (byte_count_r == 12'd3) begin
        seq_nxt = {sequence_capture_r[15:8], b};
      end
      if (hit_hi) begin
        ext_nxt = {b, extension_words_r[7:0]};
      end
      if (hit_lo) begin
        ext_nxt = {extension_words_r[15:8], b};
      end
    end else begin
      overlong_nxt = 1'b1;
    end
  end

  // Advance state; clear after the last byte
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      byte_count_r       <= '0;
      header_flags_r     <= '0;
      sequence_capture_r <= '0;
      extension_words_r  <= '0;
      overlong_r         <= 1'b0;
    end else if (advance) begin
      if (stage.item.last_byte) begin
        byte_count_r       <= '0;
        header_flags_r     <= '0;
        sequence_capture_r <= '0;
        extension_words_r  <= '0;
        overlong_r         <= 1'b0;
      end else begin
        byte_count_r       <= count_nxt;
        header_flags_r     <= flags_nxt;
        sequence_capture_r <= seq_nxt;
        extension_words_r  <= ext_nxt;
        overlong_r         <= overlong_nxt;
      end
    end
  end

  // Payload start and length
  assign ext_on     = (flags_nxt & rtphpl_pkg::EXT_FLAG) != 8'd0;
  assign pad_on     = (flags_nxt & rtphpl_pkg::PAD_FLAG) != 8'd0;
  assign short_pkt  = count_nxt < rtphpl_pkg::FIXED_HDR_BYTES;
  assign bad_ver    = (flags_nxt & rtphpl_pkg::VERSION_MASK) != rtphpl_pkg::VERSION_RTP;
  assign start_base = 7'd12 + {1'b0, flags_nxt[3:0], 2'b00};
  assign trunc      = ext_on && (({5'b0, start_base} + 12'd4) > count_nxt);
  assign ext_add    = ext_on ? (19'd4 + {1'b0, ext_nxt, 2'b00}) : '0;
  assign start_full = {12'b0, start_base} + ext_add;
  assign pad        = pad_on ? b : 8'd0;
  assign plen       = $signed({9'b0, count_nxt}) - $signed({2'b0, start_full})
                      - $signed({13'b0, pad});

  // Classify the packet
  always_comb begin
    res.status          = rtphpl_pkg::ST_NOT_RTP;
    res.payload_offset  = '0;
    res.payload_length  = '0;
    res.sequence_number = '0;
    priority if (overlong_nxt) begin
      res.status = rtphpl_pkg::ST_TOO_LONG;
    end else if (short_pkt || bad_ver) begin
      res.status         = rtphpl_pkg::ST_NOT_RTP;
      res.payload_length = count_nxt;
    end else if (trunc || plen[rtphpl_pkg::PLEN_W-1] || (plen == '0)) begin
      res.status          = rtphpl_pkg::ST_MALFORMED;
      res.sequence_number = seq_nxt;
    end else begin
      res.status          = rtphpl_pkg::ST_RTP;
      res.payload_offset  = start_full[rtphpl_pkg::COUNT_W-1:0];
      res.payload_length  = plen[rtphpl_pkg::COUNT_W-1:0];
      res.sequence_number = seq_nxt;
    end
  end

  assign res_valid = advance && stage.item.last_byte;

  `RTPHPL_ASSERT_NOW(a_count_bound, clk, rst_n, 1'b1, byte_count_r <= MAX_C, "byte count past max")
  `RTPHPL_ASSERT_NEXT(a_clear_after_last, clk, rst_n, res_valid, (byte_count_r == '0) && !overlong_r, "state not cleared after last byte")
  `RTPHPL_ASSERT_NOW(a_offset_only_rtp, clk, rst_n, res_valid && (res.status != rtphpl_pkg::ST_RTP), res.payload_offset == '0, "offset set on non-rtp result")
  `RTPHPL_ASSERT_NOW(a_overlong_sat, clk, rst_n, overlong_r, byte_count_r == MAX_C, "overlong without full count")

endmodule

// ----- design/rtphpl_out_reg.sv -----
// Output register: holds one result item until the sink takes it.
module rtphpl_out_reg (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  load,
  input  rtphpl_pkg::result_t   res,
  output logic                  free,
  rtphpl_out_if.source          out_ch
);

  logic                  valid_r;
  logic                  valid_nxt;
  rtphpl_pkg::result_t   res_r;

  // Register is free when empty or being drained
  assign free = !valid_r || out_ch.ready;

  always_comb begin
    valid_nxt = valid_r;
    if (load) begin
      valid_nxt = 1'b1;
    end else if (out_ch.ready) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      res_r <= res;
    end
  end

  assign out_ch.valid           = valid_r;
  assign out_ch.status          = res_r.status;
  assign out_ch.payload_offset  = res_r.payload_offset;
  assign out_ch.payload_length  = res_r.payload_length;
  assign out_ch.sequence_number = res_r.sequence_number;

endmodule

// ----- design/rtp_header_payload_locator.sv -----
// Top level of the RTP header payload locator.
//
//   channel  dir  handshake     payload
//   in_ch    in   valid/ready   data_byte[7:0], last_byte
//   out_ch   out  valid/ready   status[1:0], payload_offset[11:0],
//                               payload_length[11:0], sequence_number[15:0]
//
// One byte item per cycle unless a last byte is stalled; the parser register updates the capture state
// in a single pass behind the input register.
// A result is computed as its last byte leaves the input register and is held in the output register when offered.
// Reset is synchronous, active low, and clears the packet state.
// A full output register stalls only a last byte; other bytes keep flowing.
module rtp_header_payload_locator #(
  parameter int unsigned MAX_PACKET_BYTES = 2048
) (
  input  logic           clk,
  input  logic           rst_n,
  rtphpl_in_if.sink      in_ch,
  rtphpl_out_if.source   out_ch
);

  rtphpl_pkg::stage_t    stage;
  rtphpl_pkg::result_t   res;
  logic                  res_valid;
  logic                  out_free;
  logic                  advance;

  // Move the held byte on unless a result has nowhere to go
  assign advance = stage.valid && (!stage.item.last_byte || out_free);

  rtphpl_in_reg u_in_reg (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_ch   (in_ch),
    .advance (advance),
    .stage   (stage)
  );

  rtphpl_parse #(
    .MAX_PACKET_BYTES (MAX_PACKET_BYTES)
  ) u_parse (
    .clk       (clk),
    .rst_n     (rst_n),
    .stage     (stage),
    .advance   (advance),
    .res_valid (res_valid),
    .res       (res)
  );

  rtphpl_out_reg u_out_reg (
    .clk    (clk),
    .rst_n  (rst_n),
    .load   (res_valid),
    .res    (res),
    .free   (out_free),
    .out_ch (out_ch)
  );

endmodule

// ----- dv/rtp_header_payload_locator_tb.sv -----
// Testbench for the RTP header payload locator: byte stimulus, payload prediction and checks.
`timescale 1ns / 100ps

module rtp_header_payload_locator_tb;

  localparam int unsigned MAX_BYTES    = 2048;
  localparam int unsigned RANDOM_BYTES = 1250;
  localparam int unsigned HOLD_CYCLES  = 400;
  localparam int unsigned QUIET_LIMIT  = 5000;

  // Predict the locator result of each datagram and check results in order.
  class locator_scoreboard;
    int unsigned                    max_bytes;
    logic [rtphpl_pkg::COUNT_W-1:0] byte_count;
    logic [7:0]                     header_flags;
    logic [15:0]                    seq_capture;
    logic [15:0]                    ext_words;
    logic                           overlong;
    rtphpl_pkg::result_t            awaited_results[$];
    int                             errors;

    function new(int unsigned max_b);
      max_bytes = max_b;
      errors = 0;
      clear_datagram();
    endfunction

    function void clear_datagram();
      byte_count = '0;
      header_flags = '0;
      seq_capture = '0;
      ext_words = '0;
      overlong = 1'b0;
    endfunction

    function int pending();
      return awaited_results.size();
    endfunction

    // Advance the capture state by one accepted item; on the last byte queue the result.
    function void take_byte(logic [7:0] b, logic last);
      int                  ext_pos;
      int                  start;
      int                  plen;
      logic                bad;
      rtphpl_pkg::result_t r;
      if (byte_count < max_bytes) begin
        ext_pos = 12 + 4 * int'(header_flags & rtphpl_pkg::CC_MASK);
        if (byte_count == 0) header_flags = b;
        if (byte_count == 2) seq_capture[15:8] = b;
        if (byte_count == 3) seq_capture[7:0] = b;
        if (byte_count >= 12 && int'(byte_count) == ext_pos + 2) ext_words[15:8] = b;
        if (byte_count >= 12 && int'(byte_count) == ext_pos + 3) ext_words[7:0] = b;
        byte_count = byte_count + 1'b1;
      end else begin
        overlong = 1'b1;
      end
      if (!last) return;

      r = '0;
      if (overlong) begin
        r.status = rtphpl_pkg::ST_TOO_LONG;
      end else if (byte_count < rtphpl_pkg::FIXED_HDR_BYTES ||
                   (header_flags & rtphpl_pkg::VERSION_MASK) != rtphpl_pkg::VERSION_RTP) begin
        r.status = rtphpl_pkg::ST_NOT_RTP;
        r.payload_length = byte_count;
      end else begin
        start = 12 + 4 * int'(header_flags & rtphpl_pkg::CC_MASK);
        bad = 1'b0;
        if ((header_flags & rtphpl_pkg::EXT_FLAG) != 0) begin
          if (start + 4 > int'(byte_count)) bad = 1'b1;
          else start = start + 4 + 4 * int'(ext_words);
        end
        if (!bad) begin
          plen = int'(byte_count) - start;
          if ((header_flags & rtphpl_pkg::PAD_FLAG) != 0) plen = plen - int'(b);
          if (plen <= 0) begin
            bad = 1'b1;
          end else begin
            r.status = rtphpl_pkg::ST_RTP;
            r.payload_offset = start[rtphpl_pkg::COUNT_W-1:0];
            r.payload_length = plen[rtphpl_pkg::COUNT_W-1:0];
          end
        end
        if (bad) r.status = rtphpl_pkg::ST_MALFORMED;
        r.sequence_number = seq_capture;
      end
      awaited_results.push_back(r);
      clear_datagram();
    endfunction

    function void compare_field(string name, logic [15:0] want, logic [15:0] got);
      if (got !== want) begin
        $display("%0t: %s mismatch, expected %0h actual %0h", $time, name, want, got);
        errors++;
      end
    endfunction

    // Compare one accepted result with the oldest prediction.
    function void check_result(rtphpl_pkg::result_t got);
      rtphpl_pkg::result_t want;
      if (awaited_results.size() == 0) begin
        $display("%0t: result with none expected, expected none actual %0h", $time, got);
        errors++;
        return;
      end
      want = awaited_results.pop_front();
      compare_field("status", 16'(want.status), 16'(got.status));
      compare_field("payload_offset", 16'(want.payload_offset), 16'(got.payload_offset));
      compare_field("payload_length", 16'(want.payload_length), 16'(got.payload_length));
      compare_field("sequence_number", want.sequence_number, got.sequence_number);
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n;

  rtphpl_in_if  in_ch();
  rtphpl_out_if out_ch();

  rtp_header_payload_locator #(
    .MAX_PACKET_BYTES(MAX_BYTES)
  ) dut (
    .clk   (clk),
    .rst_n (rst_n),
    .in_ch (in_ch),
    .out_ch(out_ch)
  );

  locator_scoreboard sb;
  logic [7:0]        frame[$];
  bit                steady = 1'b0;
  bit                hold_results = 1'b0;
  int unsigned       random_bytes = 0;
  int unsigned       quiet_cycles = 0;

  always #4 clk = ~clk;

  // Offer one byte, idling now and then, and hold it until accepted.
  task automatic push_byte(input logic [7:0] b, input logic last);
    if (!steady && $urandom_range(99) < 13) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.data_byte <= b;
    in_ch.last_byte <= last;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    sb.take_byte(b, last);
  endtask

  task automatic send_frame();
    foreach (frame[i]) push_byte(frame[i], i == frame.size() - 1);
  endtask

  // Stop offering until every predicted result has come out.
  task automatic wait_drained();
    in_ch.valid <= 1'b0;
    do @(posedge clk); while (sb.pending() != 0);
  endtask

  task automatic fill_frame(input int total, input logic [7:0] hdr);
    frame.delete();
    for (int i = 0; i < total; i++) frame.push_back(8'($urandom_range(0, 255)));
    frame[0] = hdr;
  endtask

  // Build a datagram: mostly well-formed RTP with random content, some noise and cut ones.
  task automatic build_random_frame();
    int          kind;
    int          cc;
    int          hdr_len;
    int          pay_len;
    int          total;
    logic [7:0]  hdr;
    logic [15:0] ext_len;
    kind = $urandom_range(99);
    if (kind < 20) begin
      fill_frame($urandom_range(1, 24), 8'($urandom_range(0, 255)));
    end else begin
      hdr = {2'b10, 6'($urandom_range(0, 63))};
      cc = ($urandom_range(99) < 85) ? $urandom_range(0, 2) : $urandom_range(0, 15);
      hdr[3:0] = cc[3:0];
      ext_len = ($urandom_range(99) < 90) ? 16'($urandom_range(0, 3))
                                           : 16'($urandom_range(0, 65535));
      hdr_len = 12 + 4 * cc + (hdr[4] ? 4 + 4 * int'(ext_len) : 0);
      pay_len = $urandom_range(0, 12);
      total = hdr_len + pay_len;
      if (total > 120) total = $urandom_range(12, 120);
      else if (kind < 32) total = $urandom_range(1, total);
      fill_frame(total, hdr);
      if (15 + 4 * cc < total) begin
        frame[14 + 4 * cc] = ext_len[15:8];
        frame[15 + 4 * cc] = ext_len[7:0];
      end
      // Keep the pad count near the payload size so both sides of zero occur.
      if (hdr[5] && total > 1) begin
        frame[total - 1] = ($urandom_range(99) < 80) ? 8'($urandom_range(0, pay_len))
                                                      : 8'($urandom_range(0, 255));
      end
    end
  endtask

  // Drive results ready at random, with a long hold-off on request.
  initial begin
    out_ch.ready <= 1'b0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      if (hold_results) begin
        out_ch.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_results = 1'b0;
      end else begin
        out_ch.ready <= steady || ($urandom_range(99) >= 13);
        @(posedge clk);
      end
    end
  end

  // Check every accepted result.
  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready) begin
      sb.check_result('{status: out_ch.status, payload_offset: out_ch.payload_offset,
                        payload_length: out_ch.payload_length,
                        sequence_number: out_ch.sequence_number});
    end
  end

  // End the run when nothing moves for too long.
  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    int unsigned frames;
    int unsigned before_len;
    sb = new(MAX_BYTES);
    rst_n <= 1'b0;
    in_ch.valid <= 1'b0;
    in_ch.data_byte <= '0;
    in_ch.last_byte <= 1'b0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: one-byte datagram, cut extension with every flag, minimal payload.
    frame = {8'h00};
    send_frame();
    frame = {8'hBF, 8'h7F, 8'h00, 8'h01, 8'h00, 8'h00, 8'h00, 8'h00,
             8'h00, 8'h00, 8'h00, 8'h00};
    send_frame();
    frame = {8'h80, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF,
             8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF};
    send_frame();
    wait_drained();

    // Random datagrams with a result hold-off, a steady stretch and a drain pause.
    frames = 0;
    while (random_bytes < RANDOM_BYTES || frames < 60) begin
      if (frames == 10) hold_results = 1'b1;
      if (frames == 30) steady = 1'b1;
      if (frames == 45) steady = 1'b0;
      if (frames == 50) wait_drained();
      build_random_frame();
      before_len = frame.size();
      send_frame();
      random_bytes += before_len;
      frames++;
    end

    wait_drained();
    repeat (10) @(posedge clk);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
